FILE: rtl/countdown_display_driver_defines.svh
// ----------------------------------------------------------------------------
// countdown display driver assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef COUNTDOWN_DISPLAY_DRIVER_DEFINES_SVH
`define COUNTDOWN_DISPLAY_DRIVER_DEFINES_SVH

// same-cycle implication
`define CDD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cdd_pkg.sv
// ----------------------------------------------------------------------------
// cdd_pkg
// shared widths, codes, reset values and the segment table
// ----------------------------------------------------------------------------
`default_nettype none

package cdd_pkg;

  localparam int FRAME_BITS_DEF = 10;

  // field widths
  localparam int START_W   = 13;
  localparam int BLINK_W   = 8;
  localparam int RAMP_W    = 8;
  localparam int STEP_W    = 10;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int ACTION_W  = 2;
  localparam int POT_W     = 10;
  localparam int DIGEN_W   = 4;
  localparam int SEG_W     = 8;
  localparam int ON_W      = 11;
  localparam int COUNT_W   = 14;
  localparam int DIGIT_W   = 4;
  localparam int NUM_DIGITS = 4;
  localparam int IDX_W     = 2;
  localparam int MIN_W     = 8;
  localparam int SEC_W     = 6;
  localparam int PROD_W    = STEP_W + RAMP_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP  = 2'd3;

  // action codes, the spare code behaves as a refresh
  localparam logic [ACTION_W-1:0] ACT_REFRESH = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd2;

  // register reset values
  localparam int START_RST_INT = 1500;
  localparam logic [START_W-1:0] START_RST = START_W'(START_RST_INT);
  localparam logic [BLINK_W-1:0] BLINK_RST = 8'd60;
  localparam logic [RAMP_W-1:0]  RAMP_RST  = 8'd10;
  localparam logic [STEP_W-1:0]  STEP_RST  = 10'd100;

  // divide by constant via reciprocal
  localparam int DIV60_MUL = 17477;
  localparam int DIV60_SH  = 20;
  localparam int DIV10_MUL = 205;
  localparam int DIV10_SH  = 11;

  localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
  localparam logic [SEG_W-1:0] SEG_DP    = 8'h01;

  typedef logic [DIGIT_W-1:0] digit_t;
  // element 0 minutes tens .. element 3 seconds ones
  typedef digit_t [NUM_DIGITS-1:0] mmss_t;

  localparam mmss_t START_DIGITS_RST = {
    DIGIT_W'((START_RST_INT % 60) % 10),
    DIGIT_W'((START_RST_INT % 60) / 10),
    DIGIT_W'((START_RST_INT / 60) % 10),
    DIGIT_W'((START_RST_INT / 60) / 10)
  };

  // largest value of each digit cell before it wraps
  localparam mmss_t DIGIT_WRAP = {4'd9, 4'd5, 4'd9, 4'd9};

  typedef struct packed {
    logic load;
    logic en;
  } cell_ctl_t;

  typedef struct packed {
    logic [DIGEN_W-1:0] digit_enable;
    logic [SEG_W-1:0]   segment_pattern;
    logic [ON_W-1:0]    on_time;
    logic               asleep;
  } result_t;

  function automatic logic [SEG_W-1:0] seg_code(input digit_t d);
    logic [SEG_W-1:0] code;
    case (d)
      4'd0:    code = 8'h7E;
      4'd1:    code = 8'h0C;
      4'd2:    code = 8'hB6;
      4'd3:    code = 8'h9E;
      4'd4:    code = 8'hCC;
      4'd5:    code = 8'hDA;
      4'd6:    code = 8'hFA;
      4'd7:    code = 8'h0E;
      4'd8:    code = 8'hFE;
      4'd9:    code = 8'hDE;
      default: code = SEG_DP;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cdd_digit_cell.sv
// ----------------------------------------------------------------------------
// cdd_digit_cell
// one decimal digit of the mm:ss down counter, borrows to its neighbor
// ----------------------------------------------------------------------------
`default_nettype none

module cdd_digit_cell #(
  parameter cdd_pkg::digit_t WRAP        = 4'd9,
  parameter cdd_pkg::digit_t RESET_DIGIT = 4'd0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cdd_pkg::cell_ctl_t ctl,
  input  cdd_pkg::digit_t    load_digit,
  input  logic               borrow_in,
  output logic               borrow_out,
  output cdd_pkg::digit_t    digit_nxt
);

  cdd_pkg::digit_t digit_r;

  assign borrow_out = borrow_in && (digit_r == '0);

  always_comb begin
    if (ctl.load) begin
      digit_nxt = load_digit;
    end else if (ctl.en && borrow_in) begin
      digit_nxt = (digit_r == '0) ? WRAP : digit_r - 1'b1;
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= RESET_DIGIT;
    end else begin
      digit_r <= digit_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cdd_mmss_conv.sv
// ----------------------------------------------------------------------------
// cdd_mmss_conv
// three-stage seconds to mm:ss digit converter for the restart value
// ----------------------------------------------------------------------------
`default_nettype none

module cdd_mmss_conv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [cdd_pkg::START_W-1:0]   seconds,
  output logic                          busy,
  output cdd_pkg::mmss_t                digits
);

  localparam int P1_W = cdd_pkg::START_W + 15;
  localparam int P2_W = 16;
  localparam int P3_W = 14;

  logic                         s1_v_r, s2_v_r;
  logic [cdd_pkg::START_W-1:0]  total_r;
  logic [cdd_pkg::MIN_W-1:0]    min_r, min_nxt;
  logic [cdd_pkg::SEC_W-1:0]    sec_r, sec_nxt;
  cdd_pkg::digit_t              mt_r, mt_nxt, mo_r, mo_nxt;
  cdd_pkg::mmss_t               digits_r, digits_nxt;

  logic [P1_W-1:0]              p1;
  logic [cdd_pkg::COUNT_W-1:0]  min60, sec_full;
  logic [P2_W-1:0]              p2;
  logic [cdd_pkg::MIN_W-1:0]    mt10, mo_full;
  logic [P3_W-1:0]              p3;
  logic [2:0]                   st;
  logic [cdd_pkg::SEC_W-1:0]    st10, so_full;

  // stage 1: minutes by reciprocal multiply
  always_comb begin
    p1      = P1_W'(seconds) * P1_W'(cdd_pkg::DIV60_MUL);
    min_nxt = p1[cdd_pkg::DIV60_SH +: cdd_pkg::MIN_W];
  end

  // stage 2: seconds remainder, minutes split into tens and ones
  always_comb begin
    min60    = cdd_pkg::COUNT_W'({min_r, 6'd0}) - cdd_pkg::COUNT_W'({min_r, 2'd0});
    sec_full = cdd_pkg::COUNT_W'(total_r) - min60;
    sec_nxt  = sec_full[cdd_pkg::SEC_W-1:0];
    p2       = P2_W'(min_r) * P2_W'(cdd_pkg::DIV10_MUL);
    mt_nxt   = p2[cdd_pkg::DIV10_SH +: cdd_pkg::DIGIT_W];
    mt10     = cdd_pkg::MIN_W'({mt_nxt, 3'd0}) + cdd_pkg::MIN_W'({mt_nxt, 1'd0});
    mo_full  = min_r - mt10;
    mo_nxt   = mo_full[cdd_pkg::DIGIT_W-1:0];
  end

  // stage 3: seconds split into tens and ones
  always_comb begin
    p3         = P3_W'(sec_r) * P3_W'(cdd_pkg::DIV10_MUL);
    st         = p3[cdd_pkg::DIV10_SH +: 3];
    st10       = cdd_pkg::SEC_W'({st, 3'd0}) + cdd_pkg::SEC_W'({st, 1'd0});
    so_full    = sec_r - st10;
    digits_nxt = {so_full[cdd_pkg::DIGIT_W-1:0], cdd_pkg::DIGIT_W'(st), mo_r, mt_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      digits_r <= cdd_pkg::START_DIGITS_RST;
    end else begin
      s1_v_r <= start;
      s2_v_r <= s1_v_r;
      if (s2_v_r) begin
        digits_r <= digits_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      total_r <= seconds;
      min_r   <= min_nxt;
    end
    if (s1_v_r) begin
      sec_r <= sec_nxt;
      mt_r  <= mt_nxt;
      mo_r  <= mo_nxt;
    end
  end

  assign busy   = s1_v_r || s2_v_r;
  assign digits = digits_r;

endmodule

`default_nettype wire

FILE: rtl/countdown_display_driver.sv
// ----------------------------------------------------------------------------
// countdown_display_driver
// mm:ss seconds countdown scanned onto a four-digit seven-segment display
// ----------------------------------------------------------------------------
// Every input transfer carries one action (refresh, tick or restart) and the
// pot level, and yields exactly one result in the two-deep output register:
// the digit strobe, its segments, the lit time of the slot and the asleep
// flag. One item is taken every clock while input stall is low; the step is
// combinational logic whose longest path is the ramp floor multiply (10 x 8
// bits) feeding the level compare. The count is kept both as a binary value
// and as a chain of four digit cells that borrow into each other, so the
// shown digit is a plain select. That register absorbs result stalls, which
// raise input stall only when both of its entries are full. A write to
// start_seconds starts a three-stage conversion of the new value into mm:ss
// digits and holds input stall high while it runs; other writes cost nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module countdown_display_driver #(
  parameter int FRAME_BITS = cdd_pkg::FRAME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [cdd_pkg::ACTION_W-1:0]    in_action,
  input  logic [cdd_pkg::POT_W-1:0]       in_pot_level,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [cdd_pkg::DIGEN_W-1:0]     out_digit_enable,
  output logic [cdd_pkg::SEG_W-1:0]       out_segment_pattern,
  output logic [cdd_pkg::ON_W-1:0]        out_on_time,
  output logic                            out_asleep,
  // configuration
  input  logic                            cfg_wr_en,
  input  logic [cdd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cdd_pkg::CFG_W-1:0]       cfg_wdata
);

  // level width covers both the pot and the frame
  localparam int LVL_W  = (FRAME_BITS > cdd_pkg::POT_W) ? FRAME_BITS : cdd_pkg::POT_W;
  localparam int ONW_W  = LVL_W + 1;
  localparam int SPAN_W = cdd_pkg::COUNT_W + 1;

  localparam logic [LVL_W-1:0]           FULL_LVL  = LVL_W'((1 << FRAME_BITS) - 1);
  localparam logic [cdd_pkg::PROD_W-1:0] FULL_PROD = cdd_pkg::PROD_W'((1 << FRAME_BITS) - 1);
  localparam logic [ONW_W-1:0]           ON_FULL   = ONW_W'(1 << FRAME_BITS);
  localparam logic [ONW_W-1:0]           ON_MAX    = ONW_W'((1 << cdd_pkg::ON_W) - 1);

  // configuration registers
  logic [cdd_pkg::START_W-1:0] start_r;
  logic [cdd_pkg::BLINK_W-1:0] blink_r;
  logic [cdd_pkg::RAMP_W-1:0]  ramp_r;
  logic [cdd_pkg::STEP_W-1:0]  step_r;

  // countdown state
  logic signed [cdd_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic                               sleeping_r, sleeping_nxt;
  logic [cdd_pkg::IDX_W-1:0]          idx_r, idx_nxt, idx_base;

  // output register and skid entry
  cdd_pkg::result_t out_r, skid_r, res_nxt;
  logic             out_valid_r, skid_valid_r;

  logic fire, take, conv_busy, is_restart, is_tick, tick_live, count_pos_r;
  logic expired, ramp_on, elapsed_pos, lit;
  logic signed [cdd_pkg::COUNT_W-1:0] neg_blink;
  logic signed [SPAN_W-1:0]           start_s, ramp_lim, count_s, elapsed;
  logic [cdd_pkg::PROD_W-1:0]         ramp_prod;
  logic [LVL_W-1:0]                   floor_lvl, pot_lvl, level;
  logic [ONW_W-1:0]                   on_wide;
  logic [cdd_pkg::SEG_W-1:0]          pattern;
  cdd_pkg::digit_t                    shown;

  // digit chain
  cdd_pkg::cell_ctl_t            cell_ctl;
  cdd_pkg::mmss_t                load_digits, digits_nxt;
  logic [cdd_pkg::NUM_DIGITS:0]  borrow;

  // handshake, stall is registered state only
  assign in_stall = skid_valid_r || conv_busy;
  assign fire     = in_valid && !in_stall;
  assign take     = out_valid_r && !out_stall;

  assign is_restart  = (in_action == cdd_pkg::ACT_RESTART);
  assign is_tick     = (in_action == cdd_pkg::ACT_TICK);
  assign tick_live   = is_tick && !sleeping_r;
  assign count_pos_r = !count_r[cdd_pkg::COUNT_W-1] && (count_r != '0);

  // restart value conversion to mm:ss
  cdd_mmss_conv u_conv (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cfg_wr_en && (cfg_index == cdd_pkg::REG_START)),
    .seconds (cfg_wdata[cdd_pkg::START_W-1:0]),
    .busy    (conv_busy),
    .digits  (load_digits)
  );

  // digit cells only count while the binary count is above zero
  assign cell_ctl.load = fire && is_restart;
  assign cell_ctl.en   = fire && tick_live && count_pos_r;

  // seconds ones cell heads the borrow chain
  assign borrow[cdd_pkg::NUM_DIGITS] = 1'b1;

  for (genvar i = 0; i < cdd_pkg::NUM_DIGITS; i++) begin : g_cell
    cdd_digit_cell #(
      .WRAP        (cdd_pkg::DIGIT_WRAP[i]),
      .RESET_DIGIT (cdd_pkg::START_DIGITS_RST[i])
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (cell_ctl),
      .load_digit (load_digits[i]),
      .borrow_in  (borrow[i+1]),
      .borrow_out (borrow[i]),
      .digit_nxt  (digits_nxt[i])
    );
  end

  // count after the action
  always_comb begin
    if (is_restart) begin
      count_nxt = cdd_pkg::COUNT_W'(start_r);
    end else if (tick_live) begin
      count_nxt = count_r - 1'b1;
    end else begin
      count_nxt = count_r;
    end
  end

  // sleep once past the blink span
  assign neg_blink    = -$signed(cdd_pkg::COUNT_W'(blink_r));
  assign sleeping_nxt = (is_restart ? 1'b0 : sleeping_r) || (count_nxt < neg_blink);
  assign expired      = count_nxt[cdd_pkg::COUNT_W-1] || (count_nxt == '0);

  // ramp floor for the first seconds after start
  always_comb begin
    start_s     = $signed(SPAN_W'(start_r));
    ramp_lim    = start_s - $signed(SPAN_W'(ramp_r));
    count_s     = $signed({count_nxt[cdd_pkg::COUNT_W-1], count_nxt});
    ramp_on     = count_s > ramp_lim;
    elapsed     = start_s - count_s;
    elapsed_pos = !elapsed[SPAN_W-1] && (elapsed != '0);
    ramp_prod   = cdd_pkg::PROD_W'(step_r) *
                  cdd_pkg::PROD_W'(elapsed[cdd_pkg::RAMP_W-1:0]);
    if (!elapsed_pos) begin
      floor_lvl = FULL_LVL;
    end else if (ramp_prod >= FULL_PROD) begin
      floor_lvl = '0;
    end else begin
      floor_lvl = LVL_W'(FULL_PROD - ramp_prod);
    end
  end

  // final brightness level
  always_comb begin
    pot_lvl = LVL_W'(in_pot_level);
    level   = pot_lvl;
    if (ramp_on && (floor_lvl > level)) begin
      level = floor_lvl;
    end
    if (expired) begin
      level = FULL_LVL;
    end
  end

  // scan position only moves when something is lit
  assign lit      = !sleeping_nxt && (level != '0);
  assign idx_base = is_restart ? '0 : idx_r;
  assign idx_nxt  = lit ? idx_base + 1'b1 : idx_base;
  assign shown    = digits_nxt[idx_nxt];

  // negative counts blink 00:00 on even seconds
  always_comb begin
    if (!count_nxt[cdd_pkg::COUNT_W-1]) begin
      pattern = cdd_pkg::seg_code(shown);
    end else if (count_nxt[0]) begin
      pattern = cdd_pkg::SEG_BLANK;
    end else begin
      pattern = cdd_pkg::seg_code('0);
    end
  end

  assign on_wide = (level >= FULL_LVL) ? ON_FULL : ONW_W'(level);

  always_comb begin
    res_nxt = '0;
    res_nxt.asleep = sleeping_nxt;
    if (lit) begin
      res_nxt.digit_enable    = cdd_pkg::DIGEN_W'(1) << idx_nxt;
      res_nxt.segment_pattern = pattern;
      res_nxt.on_time         = (on_wide > ON_MAX) ? ON_MAX[cdd_pkg::ON_W-1:0]
                                                   : on_wide[cdd_pkg::ON_W-1:0];
    end
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r      <= cdd_pkg::START_RST;
      blink_r      <= cdd_pkg::BLINK_RST;
      ramp_r       <= cdd_pkg::RAMP_RST;
      step_r       <= cdd_pkg::STEP_RST;
      count_r      <= cdd_pkg::COUNT_W'(cdd_pkg::START_RST);
      sleeping_r   <= 1'b0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          cdd_pkg::REG_START: start_r <= cfg_wdata[cdd_pkg::START_W-1:0];
          cdd_pkg::REG_BLINK: blink_r <= cfg_wdata[cdd_pkg::BLINK_W-1:0];
          cdd_pkg::REG_RAMP:  ramp_r  <= cfg_wdata[cdd_pkg::RAMP_W-1:0];
          cdd_pkg::REG_STEP:  step_r  <= cfg_wdata[cdd_pkg::STEP_W-1:0];
          default: ;
        endcase
      end
      if (fire) begin
        count_r    <= count_nxt;
        sleeping_r <= sleeping_nxt;
        idx_r      <= idx_nxt;
      end
      // output register drains skid first, then takes a new transfer
      if (!out_valid_r || take) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= fire;
        end
      end else if (fire) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (fire) begin
        out_r <= res_nxt;
      end
    end else if (fire) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_digit_enable    = out_r.digit_enable;
  assign out_segment_pattern = out_r.segment_pattern;
  assign out_on_time         = out_r.on_time;
  assign out_asleep          = out_r.asleep;

endmodule

`default_nettype wire

FILE: rtl/cdd_checker.sv
// ----------------------------------------------------------------------------
// cdd_checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "countdown_display_driver_defines.svh"

module cdd_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [cdd_pkg::DIGEN_W-1:0]     out_digit_enable,
  input  logic [cdd_pkg::SEG_W-1:0]       out_segment_pattern,
  input  logic [cdd_pkg::ON_W-1:0]        out_on_time,
  input  logic                            out_asleep
);

  // a stalled result holds
  `CDD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({out_digit_enable, out_segment_pattern, out_on_time, out_asleep}), "result changed under stall")

  // at most one digit strobed
  `CDD_ASSERT_IMPL(a_one_digit, out_valid, $onehot0(out_digit_enable), "more than one digit enabled")

  // a strobed digit is lit and a dark slot strobes nothing
  `CDD_ASSERT_IMPL(a_dark_match, out_valid, (out_digit_enable == 4'd0) == (out_on_time == 11'd0), "digit strobe and on time disagree")

  // asleep is fully dark
  `CDD_ASSERT_IMPL(a_sleep_dark, out_valid && out_asleep, out_digit_enable == 4'd0 && out_segment_pattern == 8'd0 && out_on_time == 11'd0, "asleep result not dark")

endmodule

bind countdown_display_driver cdd_checker u_cdd_checker (.*);

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the mm:ss countdown display driver
// ----------------------------------------------------------------------------
// Each slot transfer is run through a cycle-free model of the countdown, the
// scan position and the brightness rules. The model's frame is queued, and
// every result transfer is compared field by field with the oldest queued
// frame. A short directed part is followed by random countdown sessions.
// Both sides of the block idle at random, and the result side also holds
// off for a long stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb;
  import cdd_pkg::*;

  localparam int RESET_CYCLES = 7;
  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 8;   // output register is two deep, a few spare
  localparam int HOLD_CYCLES = 60;
  localparam int IDLE_PCT = 22;
  localparam int SESSIONS = 12;
  localparam int SESSION_SLOTS = 100;
  localparam int FULL_LEVEL = (1 << FRAME_BITS_DEF) - 1;

  // the fourth action code behaves as a plain refresh
  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

  // seven-segment patterns of the digits 0 to 9, bit 0 is the decimal point
  localparam logic [9:0][SEG_W-1:0] DIGIT_SEGS = {
    8'hDE, 8'hFE, 8'h0E, 8'hFA, 8'hDA, 8'hCC, 8'h9E, 8'hB6, 8'h0C, 8'h7E
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [ACTION_W-1:0]  in_action;
  logic [POT_W-1:0]     in_pot_level;
  logic                 out_valid;
  logic                 out_stall;
  logic [DIGEN_W-1:0]   out_digit_enable;
  logic [SEG_W-1:0]     out_segment_pattern;
  logic [ON_W-1:0]      out_on_time;
  logic                 out_asleep;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  // model of the block: register copies and countdown state
  logic [START_W-1:0] start_reg;
  logic [BLINK_W-1:0] blink_reg;
  logic [RAMP_W-1:0]  ramp_reg;
  logic [STEP_W-1:0]  step_reg;
  int                 count_model;   // signed seconds left
  logic [IDX_W-1:0]   scan_digit;
  bit                 dozing;

  result_t     expected_frames[$];
  int          mismatches = 0;
  int unsigned cycles = 0;
  bit          steady = 1'b0;    // no idling on either side while set
  bit          hold_req = 1'b0;  // asks the receiver for one long hold-off

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  countdown_display_driver i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_pot_level        (in_pot_level),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_digit_enable    (out_digit_enable),
    .out_segment_pattern (out_segment_pattern),
    .out_on_time         (out_on_time),
    .out_asleep          (out_asleep),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  // one slot of the driver: apply the action, then work out the frame shown
  function automatic result_t next_frame(input logic [ACTION_W-1:0] action,
                                         input logic [POT_W-1:0]    pot);
    result_t frame;
    longint  level;
    longint  floor_lv;
    longint  elapsed;
    int      minutes;
    int      seconds;
    int      digit;
    frame = '0;
    if (action == ACT_RESTART) begin
      count_model = int'(start_reg);
      dozing = 1'b0;
      scan_digit = '0;
    end else if (action == ACT_TICK && !dozing) begin
      count_model = count_model - 1;
    end
    // past the blink span the display powers down until a restart
    if (!dozing && count_model < -int'(blink_reg)) dozing = 1'b1;
    if (dozing) begin
      frame.asleep = 1'b1;
      return frame;
    end
    level = pot;
    // brightness floor falls by one step per second since the start
    if (count_model > int'(start_reg) - int'(ramp_reg)) begin
      elapsed = longint'(start_reg) - count_model;
      floor_lv = FULL_LEVEL - longint'(step_reg) * elapsed;
      if (floor_lv > FULL_LEVEL) floor_lv = FULL_LEVEL;
      if (floor_lv < 0) floor_lv = 0;
      if (level < floor_lv) level = floor_lv;
    end
    if (count_model <= 0) level = FULL_LEVEL;
    // dark slot: nothing lit and the scan stays put
    if (level == 0) return frame;
    scan_digit = scan_digit + 1'b1;
    if (count_model >= 0) begin
      minutes = count_model / 60;
      seconds = count_model % 60;
      case (scan_digit)
        2'd0:    digit = minutes / 10;
        2'd1:    digit = minutes % 10;
        2'd2:    digit = seconds / 10;
        default: digit = seconds % 10;
      endcase
      // minutes tens above nine only light the decimal point
      frame.segment_pattern = (digit < 10) ? DIGIT_SEGS[digit] : SEG_DP;
    end else begin
      // expired: odd seconds blank, even seconds 00:00
      frame.segment_pattern = count_model[0] ? SEG_BLANK : DIGIT_SEGS[0];
    end
    frame.digit_enable = DIGEN_W'(1) << scan_digit;
    frame.on_time = (level >= FULL_LEVEL) ? ON_W'(FULL_LEVEL + 1) : ON_W'(level);
    return frame;
  endfunction

  // register write, only issued while no frame is outstanding
  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(value);
    @(posedge clk);
    case (idx)
      REG_START: start_reg = START_W'(value);
      REG_BLINK: blink_reg = BLINK_W'(value);
      REG_RAMP:  ramp_reg = RAMP_W'(value);
      REG_STEP:  step_reg = STEP_W'(value);
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // offer one slot, hold it until the transfer, then queue its frame;
  // valid stays high so the next slot can follow back to back
  task automatic send_slot(input logic [ACTION_W-1:0] action,
                           input logic [POT_W-1:0]    pot);
    // each cycle idles with the same odds
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_action <= action;
    in_pot_level <= pot;
    do @(posedge clk); while (in_stall);
    expected_frames.push_back(next_frame(action, pot));
  endtask

  // sender pauses until every queued frame has come out
  task automatic wait_for_frames();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
  endtask

  // scan after reset: 25:00 over all four digits, then pot extremes
  task automatic test_power_on_scan();
    repeat (4) send_slot(ACT_REFRESH, 10'd512);
    send_slot(ACT_TICK, '0);     // ramp floor lifts a zero pot
    send_slot(ACT_SPARE, '1);
  endtask

  // start above 99 minutes: minutes tens digit shows the decimal point only
  task automatic test_large_minutes();
    wait_for_frames();
    write_setting(REG_START, 8191);
    write_setting(REG_RAMP, 0);
    send_slot(ACT_RESTART, 10'd1);
    send_slot(ACT_REFRESH, '0);  // dark, scan holds
    send_slot(ACT_REFRESH, 10'd1022);
    send_slot(ACT_REFRESH, '1);
    send_slot(ACT_REFRESH, 10'd1);
  endtask

  // count through zero, blinking 00:00, then sleep; ticks ignored asleep
  task automatic test_expiry_and_sleep();
    wait_for_frames();
    write_setting(REG_START, 2);
    write_setting(REG_BLINK, 3);
    write_setting(REG_RAMP, 255);
    write_setting(REG_STEP, 1023);
    send_slot(ACT_RESTART, '0);
    repeat (6) send_slot(ACT_TICK, POT_W'($urandom_range(1023)));
    send_slot(ACT_TICK, '1);
    send_slot(ACT_REFRESH, '1);
    send_slot(ACT_RESTART, 10'd300);
  endtask

  // zero start and zero blink span: the first tick already sleeps
  task automatic test_zero_blink();
    wait_for_frames();
    write_setting(REG_START, 0);
    write_setting(REG_BLINK, 0);
    write_setting(REG_STEP, 0);
    send_slot(ACT_RESTART, 10'd7);
    send_slot(ACT_TICK, 10'd7);
  endtask

  // receiver holds off while slots keep coming, so the input stalls
  task automatic test_output_backpressure();
    wait_for_frames();
    write_setting(REG_START, 30);
    write_setting(REG_BLINK, 255);
    write_setting(REG_RAMP, 5);
    write_setting(REG_STEP, 200);
    send_slot(ACT_RESTART, 10'd100);
    hold_req = 1'b1;
    repeat (20) send_slot(($urandom_range(1) != 0) ? ACT_TICK : ACT_REFRESH,
                          POT_W'($urandom_range(1023)));
    wait_for_frames();
  endtask

  // countdown sessions: fresh settings, a restart, then mostly ticks and
  // refreshes with the odd restart or spare code mixed in
  task automatic test_random_sessions();
    int start_val;
    int pick;
    logic [ACTION_W-1:0] action;
    logic [POT_W-1:0] pot;
    for (int session = 0; session < SESSIONS; session++) begin
      wait_for_frames();
      case ($urandom_range(7))
        0:       start_val = 0;
        1:       start_val = $urandom_range(8191, 5999);
        2, 3:    start_val = $urandom_range(5999);
        default: start_val = $urandom_range(40);
      endcase
      write_setting(REG_START, start_val);
      write_setting(REG_BLINK, ($urandom_range(3) == 0) ? $urandom_range(255)
                                                        : $urandom_range(12));
      write_setting(REG_RAMP, ($urandom_range(3) == 0) ? $urandom_range(255)
                                                       : $urandom_range(15));
      write_setting(REG_STEP, $urandom_range(1023));
      // one session runs with no idling on either side
      steady = (session == 2);
      for (int slot = 0; slot < SESSION_SLOTS; slot++) begin
        pick = $urandom_range(99);
        if (slot == 0 || pick < 6) action = ACT_RESTART;
        else if (pick < 50)        action = ACT_TICK;
        else if (pick < 94)        action = ACT_REFRESH;
        else                       action = ACT_SPARE;
        case ($urandom_range(9))
          0:       pot = '0;
          1:       pot = '1;
          default: pot = POT_W'($urandom_range(1023));
        endcase
        send_slot(action, pot);
      end
      steady = 1'b0;
    end
  endtask

  // result side: random stalls, a quiet stretch, and one long hold-off
  initial begin : result_receiver
    int held;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (held = 1; held < HOLD_CYCLES; held++) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (steady) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // every result transfer against the oldest queued frame
  always @(posedge clk) begin : frame_check
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        $error("result transfer with no frame expected");
        mismatches++;
      end else begin
        want = expected_frames.pop_front();
        if (out_digit_enable !== want.digit_enable) begin
          $error("digit_enable: expected %0h, got %0h",
                 want.digit_enable, out_digit_enable);
          mismatches++;
        end
        if (out_segment_pattern !== want.segment_pattern) begin
          $error("segment_pattern: expected %0h, got %0h",
                 want.segment_pattern, out_segment_pattern);
          mismatches++;
        end
        if (out_on_time !== want.on_time) begin
          $error("on_time: expected %0d, got %0d", want.on_time, out_on_time);
          mismatches++;
        end
        if (out_asleep !== want.asleep) begin
          $error("asleep: expected %0b, got %0b", want.asleep, out_asleep);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $error("no end of run after %0d cycles", CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : main
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_REFRESH;
    in_pot_level = '0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_START;
    cfg_wdata = '0;
    // model state after reset
    start_reg = START_RST;
    blink_reg = BLINK_RST;
    ramp_reg = RAMP_RST;
    step_reg = STEP_RST;
    count_model = int'(START_RST);
    scan_digit = '0;
    dozing = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_power_on_scan();
    test_large_minutes();
    test_expiry_and_sleep();
    test_zero_blink();
    test_output_backpressure();
    test_random_sessions();

    wait_for_frames();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
